// File: sv/pbc_pkg.sv
// Shared types and constants for the point/box collision response pipeline.
// No dependencies; imported by every module of the block.
package pbc_pkg;

    // Position width (signed Q.8) and fixed widths of the register subfields
    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int CFG_W      = 3 * FIELD_W;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths, each derived from the one before it
    localparam int DIFF_W  = COORD_BITS + 1;   // position minus centre
    localparam int PROD_W  = DIFF_W + FIELD_W; // difference times axis, Q.22
    localparam int LOC_W   = PROD_W + 2;       // sum of three products, Q.22
    localparam int RND_SH  = 10;               // Q.22 to Q.12
    localparam int ROUND_W = LOC_W - RND_SH;   // local coordinate, Q.12
    localparam int RPROD_W = ROUND_W + FIELD_W; // local times axis, Q.26
    localparam int RSUM_W  = RPROD_W + 2;      // world offset, Q.26
    localparam int WLD_SH  = 18;               // Q.26 to Q.8
    localparam int RSH_W   = RSUM_W - WLD_SH;  // world offset, Q.8
    localparam int WORLD_W = RSH_W + 1;        // centre plus offset

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER     = 3'd0,
        REG_AXIS_X     = 3'd1,
        REG_AXIS_Y     = 3'd2,
        REG_AXIS_Z     = 3'd3,
        REG_HALF_SIZES = 3'd4,
        REG_MARGIN     = 3'd5
    } reg_idx_t;

    // Reset values: box at the origin, identity axes, half sizes 1.0, margin 1/256
    localparam logic [CFG_W-1:0]   CENTER_RST = 48'h0000_0000_0000;
    localparam logic [CFG_W-1:0]   AXIS_X_RST = 48'h0000_0000_4000;
    localparam logic [CFG_W-1:0]   AXIS_Y_RST = 48'h0000_4000_0000;
    localparam logic [CFG_W-1:0]   AXIS_Z_RST = 48'h4000_0000_0000;
    localparam logic [CFG_W-1:0]   HALF_RST   = 48'h0100_0100_0100;
    localparam logic [FIELD_W-1:0] MARGIN_RST = 16'h0001;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Input transaction
    typedef struct packed {
        coord_t prev_x;
        coord_t prev_y;
        coord_t prev_z;
        coord_t next_x;
        coord_t next_y;
        coord_t next_z;
    } in_t;

    // Result transaction
    typedef struct packed {
        coord_t fixed_x;
        coord_t fixed_y;
        coord_t fixed_z;
        logic   pushed_out;
    } out_t;

    // Unpacked view of the configuration registers; element k is x, y, z
    typedef struct packed {
        logic [2:0][FIELD_W-1:0]       center;
        logic [2:0][2:0][FIELD_W-1:0]  axis;   // axis[j][k]: component k of local axis j
        logic [2:0][FIELD_W-1:0]       half;
        logic [FIELD_W-1:0]            margin;
    } cfg_t;

    // Projection stage to face decision stage
    typedef struct packed {
        logic                          same;
        logic [2:0][LOC_W-1:0]         lp;
        logic [2:0][LOC_W-1:0]         lq;
        logic [2:0][COORD_BITS-1:0]    nxt;
    } proj_t;

    // Face decision stage to reconstruction stage
    typedef struct packed {
        logic                          push;
        logic [2:0][ROUND_W-1:0]       loc;
        logic [2:0][COORD_BITS-1:0]    nxt;
    } face_t;

endpackage

// File: sv/pbc_project.sv
// Projection of previous and proposed positions onto the box axes (three stages).
// Depends on pbc_pkg.
module pbc_project
    import pbc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output proj_t out_data
);

    logic [2:0] valid_reg;
    logic [2:0] stage_ready;

    logic [COORD_BITS-1:0] prv [3];
    logic [COORD_BITS-1:0] nxt [3];

    // Stage 1 registers
    logic signed [DIFF_W-1:0] dp_reg [3];
    logic signed [DIFF_W-1:0] dq_reg [3];
    logic signed [DIFF_W-1:0] dp_next [3];
    logic signed [DIFF_W-1:0] dq_next [3];
    logic                     same1_reg;
    logic                     same1_next;
    logic [2:0][COORD_BITS-1:0] nxt1_reg;

    // Stage 2 registers
    logic signed [PROD_W-1:0] pp_reg [3][3];
    logic signed [PROD_W-1:0] pq_reg [3][3];
    logic signed [PROD_W-1:0] pp_next [3][3];
    logic signed [PROD_W-1:0] pq_next [3][3];
    logic                     same2_reg;
    logic [2:0][COORD_BITS-1:0] nxt2_reg;

    // Stage 3 register
    proj_t out_reg;
    proj_t out_next;

    assign prv[0] = in_data.prev_x;
    assign prv[1] = in_data.prev_y;
    assign prv[2] = in_data.prev_z;
    assign nxt[0] = in_data.next_x;
    assign nxt[1] = in_data.next_y;
    assign nxt[2] = in_data.next_z;

    // Advance a stage when it is empty or the one after it advances
    assign stage_ready[2] = !valid_reg[2] || out_ready;
    assign stage_ready[1] = !valid_reg[1] || stage_ready[2];
    assign stage_ready[0] = !valid_reg[0] || stage_ready[1];
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

    // Offsets from the box centre and the equal-position test
    always_comb begin
        same1_next = 1'b1;
        for (int k = 0; k < 3; k++) begin
            dp_next[k] = $signed({prv[k][COORD_BITS-1], prv[k]})
                       - $signed({cfg.center[k][FIELD_W-1], cfg.center[k]});
            dq_next[k] = $signed({nxt[k][COORD_BITS-1], nxt[k]})
                       - $signed({cfg.center[k][FIELD_W-1], cfg.center[k]});
            if (prv[k] != nxt[k]) begin
                same1_next = 1'b0;
            end
        end
    end

    // Offset times axis component, Q.22
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                pp_next[j][k] = dp_reg[k] * $signed(cfg.axis[j][k]);
                pq_next[j][k] = dq_reg[k] * $signed(cfg.axis[j][k]);
            end
        end
    end

    // Sum the three products of each axis
    always_comb begin
        out_next.same = same2_reg;
        out_next.nxt  = nxt2_reg;
        for (int j = 0; j < 3; j++) begin
            out_next.lp[j] = {{2{pp_reg[j][0][PROD_W-1]}}, pp_reg[j][0]}
                           + {{2{pp_reg[j][1][PROD_W-1]}}, pp_reg[j][1]}
                           + {{2{pp_reg[j][2][PROD_W-1]}}, pp_reg[j][2]};
            out_next.lq[j] = {{2{pq_reg[j][0][PROD_W-1]}}, pq_reg[j][0]}
                           + {{2{pq_reg[j][1][PROD_W-1]}}, pq_reg[j][1]}
                           + {{2{pq_reg[j][2][PROD_W-1]}}, pq_reg[j][2]};
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) valid_reg[0] <= in_valid;
            if (stage_ready[1]) valid_reg[1] <= valid_reg[0];
            if (stage_ready[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (stage_ready[0] && in_valid) begin
            dp_reg    <= dp_next;
            dq_reg    <= dq_next;
            same1_reg <= same1_next;
            for (int k = 0; k < 3; k++) begin
                nxt1_reg[k] <= nxt[k];
            end
        end
        if (stage_ready[1] && valid_reg[0]) begin
            pp_reg    <= pp_next;
            pq_reg    <= pq_next;
            same2_reg <= same1_reg;
            nxt2_reg  <= nxt1_reg;
        end
        if (stage_ready[2] && valid_reg[1]) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: sv/pbc_face.sv
// Box hit test, entry face selection and local push-out coordinates (one stage).
// Depends on pbc_pkg.
module pbc_face
    import pbc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  proj_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output face_t out_data
);

    logic  valid_reg;
    face_t out_reg;
    face_t out_next;

    logic signed [LOC_W-1:0]   lp [3];
    logic signed [LOC_W-1:0]   lq [3];
    logic signed [LOC_W-1:0]   hq [3];
    logic signed [LOC_W-1:0]   nhq [3];
    logic signed [LOC_W-1:0]   lq_rnd [3];
    logic [2:0]                ins;
    logic [2:0]                across;
    logic [2:0]                enter_neg;
    logic [2:0]                enter_pos;
    logic                      hit;
    logic                      face_found;
    logic [1:0]                face_axis;
    logic                      face_neg;
    logic [FIELD_W:0]          dist_q8;
    logic signed [ROUND_W-1:0] push_dist;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = out_reg;

    // Slab tests against the half sizes, all strict
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            lp[j]  = $signed(in_data.lp[j]);
            lq[j]  = $signed(in_data.lq[j]);
            hq[j]  = $signed({{(LOC_W-FIELD_W-14){1'b0}}, cfg.half[j], 14'b0});
            nhq[j] = -hq[j];
            ins[j]       = (lq[j] > nhq[j]) && (lq[j] < hq[j]);
            across[j]    = ((lq[j] < nhq[j]) && (lp[j] > hq[j]))
                        || ((lq[j] > hq[j]) && (lp[j] < nhq[j]));
            enter_neg[j] = ((lp[j] < nhq[j]) && (lq[j] > nhq[j]))
                        || ((lq[j] > hq[j]) && (lp[j] < nhq[j]));
            enter_pos[j] = ((lq[j] < hq[j]) && (lp[j] > hq[j]))
                        || ((lq[j] < nhq[j]) && (lp[j] > hq[j]));
            lq_rnd[j]    = lq[j] + $signed(LOC_W'(1) << (RND_SH - 1));
        end
        hit = (&ins)
           || (ins[1] && ins[2] && across[0])
           || (ins[2] && ins[0] && across[1])
           || (ins[0] && ins[1] && across[2]);
    end

    // Pick the entry face: x, y, z in turn, the last match wins
    always_comb begin
        face_found = 1'b0;
        face_axis  = 2'd0;
        face_neg   = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (enter_neg[j]) begin
                face_found = 1'b1;
                face_axis  = 2'(j);
                face_neg   = 1'b1;
            end
            if (enter_pos[j]) begin
                face_found = 1'b1;
                face_axis  = 2'(j);
                face_neg   = 1'b0;
            end
        end
    end

    // Local coordinates: kept ones rounded to Q.12, the pushed one at half plus margin
    always_comb begin
        dist_q8   = {1'b0, cfg.half[face_axis]} + {1'b0, cfg.margin};
        push_dist = $signed({{(ROUND_W-FIELD_W-5){1'b0}}, dist_q8, 4'b0});
        out_next.push = hit && face_found && !in_data.same;
        out_next.nxt  = in_data.nxt;
        for (int j = 0; j < 3; j++) begin
            if (face_axis == 2'(j)) begin
                out_next.loc[j] = face_neg ? -push_dist : push_dist;
            end else begin
                out_next.loc[j] = lq_rnd[j][LOC_W-1:RND_SH];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: sv/pbc_rebuild.sv
// World position from local coordinates, rounding and saturation (three stages).
// Depends on pbc_pkg; the last stage is the block's output register.
module pbc_rebuild
    import pbc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  face_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    logic [2:0] valid_reg;
    logic [2:0] stage_ready;

    // Stage 1: products
    logic signed [RPROD_W-1:0]  rp_reg [3][3];
    logic signed [RPROD_W-1:0]  rp_next [3][3];
    logic                       push1_reg;
    logic [2:0][COORD_BITS-1:0] nxt1_reg;

    // Stage 2: sums
    logic signed [RSUM_W-1:0]   acc_reg [3];
    logic signed [RSUM_W-1:0]   acc_next [3];
    logic                       push2_reg;
    logic [2:0][COORD_BITS-1:0] nxt2_reg;

    // Stage 3: output
    out_t                       out_reg;
    out_t                       out_next;
    logic signed [RSUM_W-1:0]   acc_rnd [3];
    logic signed [WORLD_W-1:0]  world [3];
    logic [COORD_BITS-1:0]      res [3];

    assign stage_ready[2] = !valid_reg[2] || out_ready;
    assign stage_ready[1] = !valid_reg[1] || stage_ready[2];
    assign stage_ready[0] = !valid_reg[0] || stage_ready[1];
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

    // Local coordinate times axis component, Q.26
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                rp_next[j][k] = $signed(in_data.loc[j]) * $signed(cfg.axis[j][k]);
            end
        end
    end

    // Sum over the three local axes for each world component
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_next[k] = {{2{rp_reg[0][k][RPROD_W-1]}}, rp_reg[0][k]}
                        + {{2{rp_reg[1][k][RPROD_W-1]}}, rp_reg[1][k]}
                        + {{2{rp_reg[2][k][RPROD_W-1]}}, rp_reg[2][k]};
        end
    end

    // Round to Q.8, add the centre, saturate, and fall back to the proposed position
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_rnd[k] = acc_reg[k] + $signed(RSUM_W'(1) << (WLD_SH - 1));
            world[k]   = $signed({acc_rnd[k][RSUM_W-1], acc_rnd[k][RSUM_W-1:WLD_SH]})
                       + $signed({{(WORLD_W-FIELD_W){cfg.center[k][FIELD_W-1]}},
                                  cfg.center[k]});
            if (!push2_reg) begin
                res[k] = nxt2_reg[k];
            end else if (world[k][WORLD_W-1:COORD_BITS-1] == '0
                      || world[k][WORLD_W-1:COORD_BITS-1] == '1) begin
                res[k] = world[k][COORD_BITS-1:0];
            end else if (world[k][WORLD_W-1]) begin
                res[k] = {1'b1, {(COORD_BITS-1){1'b0}}};
            end else begin
                res[k] = {1'b0, {(COORD_BITS-1){1'b1}}};
            end
        end
        out_next.fixed_x    = res[0];
        out_next.fixed_y    = res[1];
        out_next.fixed_z    = res[2];
        out_next.pushed_out = push2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) valid_reg[0] <= in_valid;
            if (stage_ready[1]) valid_reg[1] <= valid_reg[0];
            if (stage_ready[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0] && in_valid) begin
            rp_reg    <= rp_next;
            push1_reg <= in_data.push;
            nxt1_reg  <= in_data.nxt;
        end
        if (stage_ready[1] && valid_reg[0]) begin
            acc_reg   <= acc_next;
            push2_reg <= push1_reg;
            nxt2_reg  <= nxt1_reg;
        end
        if (stage_ready[2] && valid_reg[1]) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: sv/point_box_collision_response_unit.sv
// Point versus oriented box collision response: a seven-stage elastic pipeline
// (three projection, one face, three rebuild) that takes one transaction per cycle
// while the output is not stalled.
// Each stage advances when empty or when the stage after it advances.
// Synchronous active-low reset empties the pipeline and restores the box registers.
// Depends on pbc_pkg, pbc_project, pbc_face, pbc_rebuild.
module point_box_collision_response_unit
    import pbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    logic [CFG_W-1:0]   center_reg;
    logic [CFG_W-1:0]   axis_x_reg;
    logic [CFG_W-1:0]   axis_y_reg;
    logic [CFG_W-1:0]   axis_z_reg;
    logic [CFG_W-1:0]   half_reg;
    logic [FIELD_W-1:0] margin_reg;
    cfg_t               cfg;

    logic  proj_valid;
    logic  proj_ready;
    proj_t proj_data;
    logic  face_valid;
    logic  face_ready;
    face_t face_data;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= CENTER_RST;
            axis_x_reg <= AXIS_X_RST;
            axis_y_reg <= AXIS_Y_RST;
            axis_z_reg <= AXIS_Z_RST;
            half_reg   <= HALF_RST;
            margin_reg <= MARGIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTER:     center_reg <= cfg_wdata;
                REG_AXIS_X:     axis_x_reg <= cfg_wdata;
                REG_AXIS_Y:     axis_y_reg <= cfg_wdata;
                REG_AXIS_Z:     axis_z_reg <= cfg_wdata;
                REG_HALF_SIZES: half_reg   <= cfg_wdata;
                REG_MARGIN:     margin_reg <= cfg_wdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.center  = center_reg;
    assign cfg.axis[0] = axis_x_reg;
    assign cfg.axis[1] = axis_y_reg;
    assign cfg.axis[2] = axis_z_reg;
    assign cfg.half    = half_reg;
    assign cfg.margin  = margin_reg;

    pbc_project u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (proj_valid),
        .out_ready (proj_ready),
        .out_data  (proj_data)
    );

    pbc_face u_face (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (proj_valid),
        .in_ready  (proj_ready),
        .in_data   (proj_data),
        .out_valid (face_valid),
        .out_ready (face_ready),
        .out_data  (face_data)
    );

    pbc_rebuild u_rebuild (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (face_valid),
        .in_ready  (face_ready),
        .in_data   (face_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// File: sv/pbc_checker.sv
// Port-level checks for the collision response unit, bound to the top level.
// Depends on pbc_pkg and point_box_collision_response_unit.
module pbc_checker
    import pbc_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // Reset empties the pipeline, so no result follows a reset cycle
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown straight after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // An empty or draining output stage frees every stage, so the input is open
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled although the output can advance");

    // A stall at the output closes the input only once the pipeline is full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without an output stall");

endmodule

bind point_box_collision_response_unit pbc_checker u_pbc_checker (.*);
